FILE: design/qdt_pkg.sv
`timescale 1ns / 1ps

package qdt_pkg;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_DELIM0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIM3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_DQ = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_SQ = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_ES = 3'd6;

	localparam logic [CFG_DATA_W-1:0] DELIM0_RESET = 64'h0000_0001_0000_0000;

	typedef struct packed {
		logic [7:0] char_code;
		logic       string_end;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] token_char;
		logic [7:0] open_delim;
		logic [7:0] close_delim;
	} out_item_t;

	// Character together with the flags the front end derives from it.
	typedef struct packed {
		logic [7:0] code;
		logic       at_end;
		logic       delim;
		logic       bslash;
		logic       dquote;
		logic       squote;
	} cls_t;

	typedef struct packed {
		logic allow_dq;
		logic allow_sq;
		logic allow_esc;
	} opts_t;

endpackage

FILE: design/qdt_front.sv
`timescale 1ns / 1ps

module qdt_front import qdt_pkg::*; (
	input  in_item_t     item,
	input  logic [255:0] delim_map,
	output cls_t         cls
);

	always_comb begin
		cls.code   = item.char_code;
		// A zero character ends the string just like the explicit marker.
		cls.at_end = item.string_end || (item.char_code == CH_NUL);
		cls.delim  = delim_map[item.char_code];
		cls.bslash = (item.char_code == CH_BACKSLASH);
		cls.dquote = (item.char_code == CH_DQUOTE);
		cls.squote = (item.char_code == CH_SQUOTE);
	end

endmodule

FILE: design/qdt_queue.sv
`timescale 1ns / 1ps

module qdt_queue import qdt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cls_t head
);

	cls_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: design/qdt_back.sv
`timescale 1ns / 1ps

module qdt_back import qdt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  opts_t     opts,
	input  logic      entry_valid,
	input  cls_t      entry,
	output logic      entry_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic       esc_q;
	logic       in_dq_q;
	logic       in_sq_q;
	logic       in_tok_q;
	logic       may_begin_q;
	logic       nonempty_q;
	logic [7:0] last_q;
	logic       skipping_q;

	logic       out_valid_q;
	out_item_t  out_data_q;

	logic       esc_n;
	logic       in_dq_n;
	logic       in_sq_n;
	logic       in_tok_n;
	logic       may_begin_n;
	logic       nonempty_n;
	logic [7:0] last_n;
	logic       skipping_n;
	logic       emit;
	out_item_t  res;
	logic       was_esc;
	logic       starts_esc;
	logic       quote_hit;

	assign entry_pop = entry_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		esc_n       = esc_q;
		in_dq_n     = in_dq_q;
		in_sq_n     = in_sq_q;
		in_tok_n    = in_tok_q;
		may_begin_n = may_begin_q;
		nonempty_n  = nonempty_q;
		last_n      = last_q;
		skipping_n  = skipping_q;
		emit        = 1'b0;
		res         = '0;
		was_esc     = esc_q;
		starts_esc  = entry.bslash && !esc_q && opts.allow_esc;
		quote_hit   = 1'b0;

		if (entry.at_end) begin
			if (nonempty_q) begin
				emit            = 1'b1;
				res.result_kind = KIND_END;
				res.open_delim  = last_q;
			end
			esc_n       = 1'b0;
			in_dq_n     = 1'b0;
			in_sq_n     = 1'b0;
			in_tok_n    = 1'b0;
			may_begin_n = 1'b1;
			nonempty_n  = 1'b0;
			last_n      = CH_NUL;
			skipping_n  = 1'b1;
		end else if (skipping_q && entry.delim) begin
			last_n = entry.code;
		end else begin
			skipping_n = 1'b0;

			if (entry.dquote && !in_sq_q && !was_esc && opts.allow_dq) begin
				quote_hit = 1'b1;
				if (in_dq_q) begin
					in_dq_n         = 1'b0;
					emit            = 1'b1;
					res.result_kind = KIND_END;
					res.open_delim  = CH_DQUOTE;
					res.close_delim = CH_DQUOTE;
					nonempty_n      = 1'b0;
				end else begin
					in_dq_n     = 1'b1;
					may_begin_n = 1'b1;
				end
			end
			if (entry.squote && !in_dq_n && !was_esc && opts.allow_sq) begin
				quote_hit = 1'b1;
				if (in_sq_q) begin
					in_sq_n         = 1'b0;
					emit            = 1'b1;
					res.result_kind = KIND_END;
					res.open_delim  = CH_SQUOTE;
					res.close_delim = CH_SQUOTE;
					nonempty_n      = 1'b0;
				end else begin
					in_sq_n     = 1'b1;
					may_begin_n = 1'b1;
				end
			end

			if ((entry.delim && !in_dq_n && !in_sq_n && !was_esc) || quote_hit) begin
				may_begin_n = 1'b1;
				in_tok_n    = 1'b0;
				if (nonempty_n) begin
					emit            = 1'b1;
					res.result_kind = KIND_END;
					res.open_delim  = last_q;
					res.close_delim = entry.code;
				end
				nonempty_n = 1'b0;
				last_n     = entry.code;
			end else begin
				if (may_begin_n) begin
					in_tok_n    = 1'b1;
					may_begin_n = 1'b0;
				end
				// The backslash that opens an escape is swallowed.
				if (in_tok_n && !starts_esc) begin
					emit            = 1'b1;
					res.result_kind = KIND_CHAR;
					res.token_char  = entry.code;
					nonempty_n      = 1'b1;
				end
			end

			esc_n = starts_esc;
		end
	end

	always_ff @(posedge clk) begin
		if (entry_pop && emit) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q       <= 1'b0;
			in_dq_q     <= 1'b0;
			in_sq_q     <= 1'b0;
			in_tok_q    <= 1'b0;
			may_begin_q <= 1'b1;
			nonempty_q  <= 1'b0;
			last_q      <= CH_NUL;
			skipping_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (entry_pop) begin
				esc_q       <= esc_n;
				in_dq_q     <= in_dq_n;
				in_sq_q     <= in_sq_n;
				in_tok_q    <= in_tok_n;
				may_begin_q <= may_begin_n;
				nonempty_q  <= nonempty_n;
				last_q      <= last_n;
				skipping_q  <= skipping_n;
				out_valid_q <= emit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		entry_pop && entry.at_end |=> skipping_q && may_begin_q && !nonempty_q && !esc_q)
		else $error("state not cleared after end of string");

	a_tok_flags: assert property (@(posedge clk) disable iff (!arst_n)
		in_tok_q != may_begin_q)
		else $error("token start and inside-token flags disagree");

	a_one_quote: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_dq_q && in_sq_q))
		else $error("inside both quote kinds at once");

	a_nonempty_in_tok: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q |-> in_tok_q)
		else $error("nonempty token while not inside a token");

endmodule

FILE: design/quoted_delimiter_tokenizer.sv
`timescale 1ns / 1ps

// Quoted-string tokenizer.
// Input channel (in_valid / in_stall / in_data): one beat per character, or an
// end-of-string beat (string_end set, or a zero character). Output channel
// (out_valid / out_stall / out_data): zero or one result beat per input beat,
// either a token character or a token end carrying its opening and closing
// delimiter characters.
// Configuration: write cfg_data to register cfg_index with cfg_we while idle.
// Indexes 0 to 3 hold the delimiter bit map, 4 to 6 the double-quote,
// single-quote and backslash-escape enables; other indexes are ignored.
// Path: a result passes the queue and then the back end's output register.
// Throughput: one character per cycle while out_stall is low, set by the
// back-end state update; a two-entry queue lies between classification and it.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and in_stall rises once both queue entries are taken.
// Reset clears the tokenizer state and the queue and loads the register
// defaults: only the space character is a delimiter, all features enabled.
module quoted_delimiter_tokenizer import qdt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CFG_DATA_W-1:0] delim_q [4];
	opts_t                 opts_q;

	cls_t cls;
	cls_t head;
	logic full;
	logic not_empty;
	logic pop;
	logic push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q[0]       <= DELIM0_RESET;
			delim_q[1]       <= '0;
			delim_q[2]       <= '0;
			delim_q[3]       <= '0;
			opts_q.allow_dq  <= 1'b1;
			opts_q.allow_sq  <= 1'b1;
			opts_q.allow_esc <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELIM0:   delim_q[0] <= cfg_data;
				CFG_DELIM1:   delim_q[1] <= cfg_data;
				CFG_DELIM2:   delim_q[2] <= cfg_data;
				CFG_DELIM3:   delim_q[3] <= cfg_data;
				CFG_ALLOW_DQ: opts_q.allow_dq  <= cfg_data[0];
				CFG_ALLOW_SQ: opts_q.allow_sq  <= cfg_data[0];
				CFG_ALLOW_ES: opts_q.allow_esc <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign in_stall = full;
	assign push     = in_valid && !full;

	qdt_front u_front (
		.item      (in_data),
		.delim_map ({delim_q[3], delim_q[2], delim_q[1], delim_q[0]}),
		.cls       (cls)
	);

	qdt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	qdt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.opts        (opts_q),
		.entry_valid (not_empty),
		.entry       (head),
		.entry_pop   (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import qdt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int unsigned PHASES = 9;
	localparam int unsigned PHASE_ITEMS = 72;
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef struct packed {
		in_item_t  item;
		logic      fixed;
		out_item_t want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Mirror of the configuration registers.
	logic [63:0] delim_bits [4];
	logic        dq_on, sq_on, esc_on;

	// Tokenizer state as the block should hold it.
	logic       esc_pend, in_dq, in_sq, in_tok, may_begin, tok_has_chars, at_head;
	logic [7:0] prev_delim;

	out_item_t  token_q [$];
	out_item_t  want_res;
	int         errors = 0;
	int         burst_left = 0;
	logic       gappy = 1'b1;
	int         rx_span = 0;
	int         rx_mode = 0;
	dir_row_t   dir_tab [24];

	quoted_delimiter_tokenizer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void clear_tokenizer();
		esc_pend = 1'b0;
		in_dq = 1'b0;
		in_sq = 1'b0;
		in_tok = 1'b0;
		may_begin = 1'b1;
		tok_has_chars = 1'b0;
		prev_delim = CH_NUL;
		at_head = 1'b1;
	endfunction

	function automatic void set_mirror(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_DELIM0, CFG_DELIM1, CFG_DELIM2, CFG_DELIM3: delim_bits[idx[1:0]] = val;
			CFG_ALLOW_DQ: dq_on = val[0];
			CFG_ALLOW_SQ: sq_on = val[0];
			CFG_ALLOW_ES: esc_on = val[0];
			default: ;
		endcase
	endfunction

	// Advances the tokenizer by one beat; returns 1 when the beat yields a result.
	function automatic bit advance_tokenizer(input in_item_t it, output out_item_t res);
		logic [7:0] c;
		logic       delim_hit, was_esc, esc_start, qhit;
		bit         got;
		c = it.char_code;
		res = '0;
		got = 1'b0;
		qhit = 1'b0;
		if (it.string_end || c == CH_NUL) begin
			if (tok_has_chars) begin
				res = '{KIND_END, CH_NUL, prev_delim, CH_NUL};
				got = 1'b1;
			end
			clear_tokenizer();
			return got;
		end
		delim_hit = delim_bits[c[7:6]][c[5:0]];
		if (at_head) begin
			if (delim_hit) begin
				prev_delim = c;
				return 1'b0;
			end
			at_head = 1'b0;
		end
		was_esc = esc_pend;
		esc_start = (c == CH_BACKSLASH) && !was_esc && esc_on;
		if (c == CH_DQUOTE && !in_sq && !was_esc && dq_on) begin
			qhit = 1'b1;
			if (in_dq) begin
				res = '{KIND_END, CH_NUL, CH_DQUOTE, CH_DQUOTE};
				got = 1'b1;
				tok_has_chars = 1'b0;
			end else begin
				may_begin = 1'b1;
			end
			in_dq = !in_dq;
		end
		if (c == CH_SQUOTE && !in_dq && !was_esc && sq_on) begin
			qhit = 1'b1;
			if (in_sq) begin
				res = '{KIND_END, CH_NUL, CH_SQUOTE, CH_SQUOTE};
				got = 1'b1;
				tok_has_chars = 1'b0;
			end else begin
				may_begin = 1'b1;
			end
			in_sq = !in_sq;
		end
		if ((delim_hit && !in_dq && !in_sq && !was_esc) || qhit) begin
			may_begin = 1'b1;
			in_tok = 1'b0;
			if (tok_has_chars) begin
				res = '{KIND_END, CH_NUL, prev_delim, c};
				got = 1'b1;
			end
			tok_has_chars = 1'b0;
			prev_delim = c;
		end else begin
			if (may_begin) begin
				in_tok = 1'b1;
				may_begin = 1'b0;
			end
			if (in_tok && !esc_start) begin
				res = '{KIND_CHAR, c, CH_NUL, CH_NUL};
				got = 1'b1;
				tok_has_chars = 1'b1;
			end
		end
		esc_pend = esc_start;
		return got;
	endfunction

	// Mostly text with quotes, escapes and delimiters, some raw bytes and end markers.
	function automatic in_item_t rand_item();
		in_item_t it;
		int       r;
		int       tries;
		it.string_end = 1'b0;
		it.char_code = 8'h61 + 8'($urandom_range(0, 25));
		r = $urandom_range(0, 99);
		if (r < 6) begin
			it.string_end = 1'b1;
			it.char_code = 8'($urandom_range(0, 255));
		end else if (r < 9) begin
			it.char_code = CH_NUL;
		end else if (r < 24) begin
			tries = 0;
			do begin
				it.char_code = 8'($urandom_range(1, 255));
				tries++;
			end while (!delim_bits[it.char_code[7:6]][it.char_code[5:0]] && tries < 16);
		end else if (r < 34) begin
			it.char_code = CH_DQUOTE;
		end else if (r < 43) begin
			it.char_code = CH_SQUOTE;
		end else if (r < 51) begin
			it.char_code = CH_BACKSLASH;
		end else if (r < 61) begin
			it.char_code = 8'($urandom_range(1, 255));
		end
		return it;
	endfunction

	task automatic feed(input in_item_t it, input logic fixed, input out_item_t want);
		out_item_t res;
		if (burst_left == 0) begin
			if (gappy) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		if (advance_tokenizer(it, res))
			token_q.push_back(fixed ? want : res);
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		set_mirror(idx, val);
	endtask

	task automatic configure(input int p);
		logic [63:0] m [4];
		logic [2:0]  en;
		logic [63:0] v;
		logic [7:0]  codes [6];
		int          k;
		codes = '{8'h20, 8'h2C, 8'h09, 8'h7F, 8'h80, 8'hFF};
		for (k = 0; k < 4; k++) m[k] = {$urandom, $urandom};
		en = 3'($urandom_range(0, 7));
		case (p)
			0: begin
				m = '{DELIM0_RESET, 64'h0, 64'h0, 64'h0};
				en = 3'b111;
			end
			1: begin
				m = '{64'h0, 64'h0, 64'h0, 64'h0};
				en = 3'b111;
			end
			2: begin
				m = '{'1, '1, '1, '1};
				en = 3'b111;
			end
			3, 5, 7: begin
				m = '{64'h0, 64'h0, 64'h0, 64'h0};
				for (k = 0; k < 6; k++)
					if (k < 3 || p != 3) m[codes[k][7:6]][codes[k][5:0]] = 1'b1;
				// Double quote doubles as a plain delimiter while its grouping is off.
				if (p == 3) begin
					m[CH_DQUOTE[7:6]][CH_DQUOTE[5:0]] = 1'b1;
					en = 3'b010;
				end else if (p == 5) begin
					en = 3'b000;
				end
			end
			6: en = 3'b101;
			default: ;
		endcase
		write_reg(CFG_DELIM0, m[0]);
		write_reg(CFG_DELIM1, m[1]);
		write_reg(CFG_DELIM2, m[2]);
		write_reg(CFG_DELIM3, m[3]);
		v = {$urandom, $urandom};
		v[0] = en[2];
		write_reg(CFG_ALLOW_DQ, v);
		v = {$urandom, $urandom};
		v[0] = en[1];
		write_reg(CFG_ALLOW_SQ, v);
		v = {$urandom, $urandom};
		v[0] = en[0];
		write_reg(CFG_ALLOW_ES, v);
		if (p >= 6) write_reg(CFG_UNUSED, {$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	// Receiver stall pattern: spans of no stall, light, heavy and periodic stalling.
	always @(posedge clk) begin
		if (rx_span == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_span <= $urandom_range(20, 150);
		end else begin
			rx_span <= rx_span - 1;
		end
		case (rx_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (rx_span % 16 < 6);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (token_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat: expected none, got kind %0d char %h open %h close %h",
					$time, out_data.result_kind, out_data.token_char, out_data.open_delim,
					out_data.close_delim);
			end else begin
				want_res = token_q.pop_front();
				if (out_data.result_kind !== want_res.result_kind
						|| out_data.token_char !== want_res.token_char
						|| out_data.open_delim !== want_res.open_delim
						|| out_data.close_delim !== want_res.close_delim) begin
					errors++;
					$display("%0t: mismatch: expected kind %0d char %h open %h close %h",
						$time, want_res.result_kind, want_res.token_char,
						want_res.open_delim, want_res.close_delim);
					$display("%0t:           actual   kind %0d char %h open %h close %h",
						$time, out_data.result_kind, out_data.token_char,
						out_data.open_delim, out_data.close_delim);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		int p;
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		delim_bits = '{DELIM0_RESET, 64'h0, 64'h0, 64'h0};
		dq_on = 1'b1;
		sq_on = 1'b1;
		esc_on = 1'b1;
		clear_tokenizer();

		// Reset-default registers: space is the only delimiter, everything enabled.
		dir_tab = '{
			'{'{8'h20, 1'b0}, 1'b0, '0},
			'{'{8'h61, 1'b0}, 1'b1, '{KIND_CHAR, 8'h61, CH_NUL, CH_NUL}},
			'{'{8'h20, 1'b0}, 1'b1, '{KIND_END, CH_NUL, 8'h20, 8'h20}},
			'{'{CH_DQUOTE, 1'b0}, 1'b0, '0},
			'{'{8'h20, 1'b0}, 1'b1, '{KIND_CHAR, 8'h20, CH_NUL, CH_NUL}},
			'{'{CH_SQUOTE, 1'b0}, 1'b1, '{KIND_CHAR, CH_SQUOTE, CH_NUL, CH_NUL}},
			'{'{CH_DQUOTE, 1'b0}, 1'b1, '{KIND_END, CH_NUL, CH_DQUOTE, CH_DQUOTE}},
			'{'{CH_SQUOTE, 1'b0}, 1'b0, '0},
			'{'{CH_SQUOTE, 1'b0}, 1'b1, '{KIND_END, CH_NUL, CH_SQUOTE, CH_SQUOTE}},
			'{'{CH_BACKSLASH, 1'b0}, 1'b0, '0},
			'{'{CH_DQUOTE, 1'b0}, 1'b1, '{KIND_CHAR, CH_DQUOTE, CH_NUL, CH_NUL}},
			'{'{CH_BACKSLASH, 1'b0}, 1'b0, '0},
			'{'{CH_BACKSLASH, 1'b0}, 1'b1, '{KIND_CHAR, CH_BACKSLASH, CH_NUL, CH_NUL}},
			'{'{8'hFF, 1'b0}, 1'b1, '{KIND_CHAR, 8'hFF, CH_NUL, CH_NUL}},
			'{'{CH_NUL, 1'b0}, 1'b0, '0},
			'{'{8'hFF, 1'b1}, 1'b0, '0},
			'{'{CH_DQUOTE, 1'b0}, 1'b0, '0},
			'{'{8'h71, 1'b0}, 1'b0, '0},
			'{'{8'hFF, 1'b1}, 1'b0, '0},
			'{'{8'h01, 1'b0}, 1'b0, '0},
			'{'{8'hAA, 1'b1}, 1'b1, '{KIND_END, CH_NUL, CH_NUL, CH_NUL}},
			'{'{CH_BACKSLASH, 1'b0}, 1'b0, '0},
			'{'{CH_NUL, 1'b0}, 1'b0, '0},
			'{'{8'h80, 1'b1}, 1'b0, '0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			feed(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].want);

		for (p = 0; p < PHASES; p++) begin
			wait_quiet();
			configure(p);
			gappy = (p % 4 != 2);
			burst_left = 0;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				// Let the output side run dry partway through some phases.
				if (i == PHASE_ITEMS / 2 && p % 3 == 1) wait_quiet();
				feed(rand_item(), 1'b0, '0);
			end
		end

		wait_quiet();
		if (errors == 0 && token_q.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

FILE: sim.f
design/qdt_pkg.sv
design/qdt_front.sv
design/qdt_queue.sv
design/qdt_back.sv
design/quoted_delimiter_tokenizer.sv
tb/tb.sv
